FILE: src/hrat_pkg.sv
package hrat_pkg;

  localparam int unsigned NumBuckets = 256;
  localparam int unsigned BucketBits = $clog2(NumBuckets);
  localparam int unsigned Ways = 8;
  localparam int unsigned WayBits = $clog2(Ways);
  localparam int unsigned FillBits = $clog2(Ways + 1);
  localparam int unsigned KeyBits = 64;
  localparam int unsigned HandleBits = 16;
  localparam int unsigned LogBits = 4;
  localparam int unsigned AddrBits = 3;
  localparam int unsigned DataBits = 32;

  localparam logic [KeyBits-1:0] HashMult = 64'h2545F4914F6CDD1D;
  localparam logic [LogBits-1:0] LogReset = LogBits'(BucketBits);

  localparam logic ActInsert = 1'b0;
  localparam logic ActLookup = 1'b1;

  localparam logic RegBucketCountLog2 = 1'b0;

  typedef struct packed {
    logic                  action;
    logic [KeyBits-1:0]    key;
    logic [HandleBits-1:0] value_handle;
  } in_t;

  typedef struct packed {
    logic                  hit;
    logic [HandleBits-1:0] found_handle;
    logic                  bucket_full;
  } out_t;

  typedef struct packed {
    logic [KeyBits-1:0]    key;
    logic [HandleBits-1:0] handle;
  } entry_t;

  typedef entry_t [Ways-1:0] row_t;

  typedef struct packed {
    logic                  hit;
    logic [HandleBits-1:0] handle;
  } match_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_e;

  // Only the low bucket bits of the product survive the mask and the modulo,
  // so only the low bits of the mixed key and of the multiplier matter.
  function automatic logic [BucketBits-1:0] bucket_hash(
    input logic [KeyBits-1:0] key,
    input logic [LogBits-1:0] lg
  );
    logic [KeyBits-1:0]      v;
    logic [2*BucketBits-1:0] prod;
    logic [BucketBits-1:0]   mask;
    v = key ^ (key >> 12);
    v = v ^ (v << 25);
    v = v ^ (v >> 27);
    prod = v[BucketBits-1:0] * HashMult[BucketBits-1:0];
    if (lg >= LogBits'(BucketBits)) begin
      mask = '1;
    end else begin
      mask = BucketBits'((2*BucketBits)'(1) << lg) - BucketBits'(1);
    end
    return prod[BucketBits-1:0] & mask;
  endfunction

endpackage

FILE: src/hrat_match.sv
module hrat_match (
  input  hrat_pkg::row_t                       row_i,
  input  logic [hrat_pkg::KeyBits-1:0]         key_i,
  input  logic [hrat_pkg::FillBits-1:0]        fill_i,
  output hrat_pkg::match_t                     match_o
);
  import hrat_pkg::*;

  // The first way below the fill count whose key matches wins.
  always_comb begin
    match_o = '0;
    for (int i = Ways - 1; i >= 0; i--) begin
      if ((FillBits'(i) < fill_i) && (row_i[WayBits'(i)].key == key_i)) begin
        match_o.hit    = 1'b1;
        match_o.handle = row_i[WayBits'(i)].handle;
      end
    end
  end

endmodule

FILE: src/hashed_return_address_table_unit.sv
// Hashed return-address table.
// Items enter on the input channel (in_valid_i / in_ready_o, payload in_data_i)
// and each one produces exactly one result item on the output channel
// (out_valid_o / out_ready_i, payload out_data_o). An insert appends the key and
// handle to its bucket, or reports bucket_full when all eight ways are taken;
// a lookup returns the handle of the oldest matching entry, or a miss.
// Each item passes accept and hash, bucket row read from the row memory, then
// way compare with write-back into the result register. No new item is taken
// until the previous one has left the compare step; the next item is taken in
// the cycle after the result is registered. The result register lets a new
// item be accepted while the previous result still waits; if the receiver
// stalls long enough the evaluation step holds its row data until the
// register frees up. Reset clears every bucket fill count at once through
// per-bucket valid bits, so the block accepts items in the first cycle after
// reset. bucket_count_log2 resets to 8 and is written through the APB port at
// address 0, by the user only while idle; the block does not enforce this.
module hashed_return_address_table_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hrat_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hrat_pkg::out_t                    out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hrat_pkg::AddrBits-1:0]     paddr,
  input  logic [hrat_pkg::DataBits-1:0]     pwdata,
  output logic [hrat_pkg::DataBits-1:0]     prdata,
  output logic                              pready
);
  import hrat_pkg::*;

  state_e state_q, state_d;

  logic [LogBits-1:0]    lg_q;
  in_t                   item_q;
  logic [BucketBits-1:0] idx_q;
  logic [NumBuckets-1:0] fill_valid_q;
  logic                  out_valid_q;
  out_t                  out_q;

  // Bucket rows and fill counts live in synchronous memories.
  row_t                  row_mem  [NumBuckets];
  logic [FillBits-1:0]   fill_mem [NumBuckets];
  row_t                  row_rd_q;
  logic [FillBits-1:0]   fill_rd_q;

  logic                  accept;
  logic                  eval_go;
  logic                  cfg_wr;
  logic                  rd_en;
  logic [FillBits-1:0]   fill_cur;
  logic                  is_full;
  logic                  do_insert;
  match_t                match;
  out_t                  result;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegBucketCountLog2);

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegBucketCountLog2) begin
      prdata = DataBits'(lg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= LogReset;
    end else if (cfg_wr) begin
      lg_q <= pwdata[LogBits-1:0];
    end
  end

  // Sequencer.
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign eval_go    = (state_q == S_EVAL) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (eval_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_en = (state_q == S_READ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The bucket index is computed as the item is taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      idx_q  <= bucket_hash(in_data_i.key, lg_q);
    end
  end

  // Memory read ports.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      row_rd_q  <= row_mem[idx_q];
      fill_rd_q <= fill_mem[idx_q];
    end
  end

  // A bucket never written since reset counts as empty.
  assign fill_cur  = fill_valid_q[idx_q] ? fill_rd_q : '0;
  assign is_full   = (fill_cur >= FillBits'(Ways));
  assign do_insert = eval_go && (item_q.action == ActInsert) && !is_full;

  hrat_match u_match (
    .row_i   (row_rd_q),
    .key_i   (item_q.key),
    .fill_i  (fill_cur),
    .match_o (match)
  );

  // Memory write ports.
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      row_mem[idx_q][fill_cur[WayBits-1:0]] <= {item_q.key, item_q.value_handle};
      fill_mem[idx_q] <= fill_cur + FillBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_valid_q <= '0;
    end else if (do_insert) begin
      fill_valid_q[idx_q] <= 1'b1;
    end
  end

  // Result register.
  always_comb begin
    result = '0;
    if (item_q.action == ActLookup) begin
      result.hit          = match.hit;
      result.found_handle = match.handle;
    end else begin
      result.bucket_full  = is_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: verif/hashed_return_address_table_unit_tb.sv
`timescale 1ns / 1ps

module hashed_return_address_table_unit_tb;
  import hrat_pkg::*;

  // The watchdog ends the run after this many cycles in which neither channel
  // moves an item. The longest quiet stretch in a correct run is the receiver's
  // long hold-off.
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned PhaseItems = 75;

  localparam logic [KeyBits-1:0] MixMult = 64'd2685821657736338717;
  localparam logic [AddrBits-1:0] Log2Addr = AddrBits'(4 * int'(RegBucketCountLog2));

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [DataBits-1:0] pwdata = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;

  hashed_return_address_table_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Shadow copy of the table. The entry arrays are only read below a bucket's
  // fill count, so their start values never matter.
  logic [LogBits-1:0]    shadow_log2 = LogReset;
  int unsigned           shadow_fill [NumBuckets] = '{default: 0};
  logic [KeyBits-1:0]    shadow_keys [NumBuckets][Ways];
  logic [HandleBits-1:0] shadow_handles [NumBuckets][Ways];

  // Responses predicted for accepted requests, oldest first.
  out_t                  pending_responses [$];
  // Keys issued as inserts, so that later requests can find them again.
  logic [KeyBits-1:0]    issued_keys [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_request = 0;
  bit          no_idle = 1'b0;

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  // One xorshift64* round, with the product kept modulo 2^64.
  function automatic logic [KeyBits-1:0] mix_key(logic [KeyBits-1:0] key);
    logic [KeyBits-1:0] v;
    v = key;
    v = v ^ (v >> 12);
    v = v ^ (v << 25);
    v = v ^ (v >> 27);
    return v * MixMult;
  endfunction

  // The mask may select more buckets than exist; the modulo by the bucket
  // count then folds the index back into the table.
  function automatic logic [BucketBits-1:0] bucket_index(logic [KeyBits-1:0] key);
    logic [KeyBits-1:0] mask;
    mask = (64'd1 << shadow_log2) - 64'd1;
    return BucketBits'((mix_key(key) & mask) % NumBuckets);
  endfunction

  // Applies one request to the shadow table and returns the response that
  // the block must give for it.
  function automatic out_t table_response(in_t req);
    logic [BucketBits-1:0] b;
    int unsigned           fill;
    int unsigned           i;
    out_t                  res;
    res = '0;
    b = bucket_index(req.key);
    fill = shadow_fill[b];
    if (req.action == ActInsert) begin
      if (fill >= Ways) begin
        res.bucket_full = 1'b1;
      end else begin
        shadow_keys[b][WayBits'(fill)] = req.key;
        shadow_handles[b][WayBits'(fill)] = req.value_handle;
        shadow_fill[b] = fill + 1;
      end
    end else begin
      for (i = 0; i < fill; i++) begin
        if (!res.hit && shadow_keys[b][WayBits'(i)] == req.key) begin
          res.hit = 1'b1;
          res.found_handle = shadow_handles[b][WayBits'(i)];
        end
      end
    end
    return res;
  endfunction

  // Both channels are watched at the rising edge. A result leaving in the
  // same cycle as a new request enters always belongs to an older request,
  // so the check runs before the new prediction is queued.
  always @(posedge clk_i) begin : monitor
    out_t want;
    bit   moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (pending_responses.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("%0t: unexpected result hit=%0b handle=%h full=%0b", $realtime,
                     out_data.hit, out_data.found_handle, out_data.bucket_full);
          end
        end else begin
          want = pending_responses.pop_front();
          if (out_data.hit !== want.hit || out_data.found_handle !== want.found_handle ||
              out_data.bucket_full !== want.bucket_full) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
              $display("%0t: expected hit=%0b handle=%h full=%0b, got hit=%0b handle=%h full=%0b",
                       $realtime, want.hit, want.found_handle, want.bucket_full,
                       out_data.hit, out_data.found_handle, out_data.bucket_full);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        pending_responses.push_back(table_response(in_data));
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  // The receiver draws a wait before each item. A long hold-off requested by
  // a test is counted out here, independent of the sender.
  initial begin : receiver
    int unsigned wait_cycles;
    forever begin
      if (hold_request > 0) begin
        wait_cycles = hold_request;
        hold_request = 0;
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (wait_cycles > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (wait_cycles - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  function automatic in_t make_request(logic act, logic [KeyBits-1:0] key,
                                       logic [HandleBits-1:0] handle);
    in_t req;
    req.action = act;
    req.key = key;
    req.value_handle = handle;
    return req;
  endfunction

  function automatic logic [KeyBits-1:0] random_key();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return '0;
    if (pick < 6) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Most requests work on keys that were inserted before, so that lookups
  // hit, duplicates pile up in buckets and buckets run full. The rest are
  // fresh keys and lookups that should miss.
  function automatic in_t random_request();
    logic [KeyBits-1:0] key;
    logic               act;
    bit                 reuse;
    act = $urandom_range(0, 1) ? ActLookup : ActInsert;
    reuse = issued_keys.size() != 0 &&
            $urandom_range(0, 99) < (act == ActLookup ? 75 : 30);
    key = reuse ? issued_keys[$urandom_range(0, issued_keys.size() - 1)] : random_key();
    if (act == ActInsert) issued_keys.push_back(key);
    return make_request(act, key, HandleBits'($urandom()));
  endfunction

  // Presents one item and returns at the edge where it is accepted. Valid
  // stays high into the next call unless that call draws a gap.
  task automatic send_item(input in_t req);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // The register is only written once the block has returned every result
  // and had a few cycles to settle.
  task automatic set_bucket_log2(input logic [LogBits-1:0] lg);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= Log2Addr;
    pwdata <= DataBits'(lg);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_log2 = lg;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_empty_lookup();
    send_item(make_request(ActLookup, '0, '1));
  endtask

  // Extreme keys and handles, a duplicate key and a miss.
  task automatic test_insert_and_lookup();
    send_item(make_request(ActInsert, '0, '1));
    send_item(make_request(ActInsert, '1, '0));
    send_item(make_request(ActInsert, '0, 16'h1234));
    send_item(make_request(ActLookup, '0, '0));
    send_item(make_request(ActLookup, '1, '1));
    send_item(make_request(ActLookup, 64'h0123_4567_89AB_CDEF, '0));
  endtask

  // With a single bucket every key lands in the same place, so the bucket
  // runs full and later inserts are dropped.
  task automatic test_full_bucket();
    int unsigned n;
    set_bucket_log2(4'd0);
    for (n = 0; n < Ways; n++) begin
      send_item(make_request(ActInsert, 64'hFFFF_0000_0000_0000 | 64'(n), HandleBits'(n + 1)));
    end
    send_item(make_request(ActInsert, 64'hDEAD_BEEF_0000_0001, 16'hAAAA));
    send_item(make_request(ActLookup, 64'hDEAD_BEEF_0000_0001, '0));
    send_item(make_request(ActLookup, 64'hFFFF_0000_0000_0003, '0));
  endtask

  // Entries filed under one mask stay where they are when the mask changes,
  // and masks wider than the table fold back into it.
  task automatic test_mask_changes();
    set_bucket_log2(4'd8);
    send_item(make_request(ActLookup, 64'hFFFF_0000_0000_0005, '0));
    send_item(make_request(ActLookup, '1, '0));
    set_bucket_log2(4'd15);
    send_item(make_request(ActInsert, 64'h8000_0000_0000_0000, 16'h8001));
    send_item(make_request(ActLookup, 64'h8000_0000_0000_0000, '0));
    set_bucket_log2(4'd9);
    send_item(make_request(ActLookup, 64'h8000_0000_0000_0000, '0));
  endtask

  task automatic test_random_phases();
    logic [LogBits-1:0] phase_log2 [8] = '{4'd8, 4'd2, 4'd15, 4'd6, 4'd0, 4'd11, 4'd4, 4'd8};
    int unsigned p;
    for (p = 0; p < 8; p++) begin
      set_bucket_log2(phase_log2[3'(p)]);
      repeat (PhaseItems) send_item(random_request());
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (60) send_item(random_request());
    no_idle = 1'b0;
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // result register and the pipeline fill and the input stalls.
  task automatic test_output_backpressure();
    hold_request = HoldOffCycles;
    repeat (24) send_item(random_request());
  endtask

  initial begin : run
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_lookup();
    test_insert_and_lookup();
    test_full_bucket();
    test_mask_changes();
    test_random_phases();
    test_back_to_back();
    test_output_backpressure();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
